@@ sv/stc_pkg.sv @@
// shared types, constants and microcode rom for the sinc series evaluator
package stc_pkg;

	localparam int TERM_LIMIT_DEF = 64;
	localparam int FRAC_BITS_DEF  = 32;

	localparam int ARG_W   = 32;
	localparam int ARG_FRAC = 28;
	localparam int SUM_W   = 48;
	localparam int USED_W  = 7;
	localparam int TOL_W   = 32;
	localparam int CFG_W   = 32;
	localparam int SQ_W    = 64;
	localparam int MAG_W   = 63;
	localparam int D_W     = 16;
	localparam int ACC_W   = 128;
	localparam int CNT_W   = $clog2(MAG_W);
	localparam int PC_W    = 4;

	localparam logic [TOL_W-1:0]  TOL_RST = 32'd4295;
	localparam logic [USED_W-1:0] MAX_TERMS_RST = 7'd16;

	typedef enum logic [0:0] {
		REG_TOLERANCE = 1'b0,
		REG_MAX_TERMS = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		OP_NOP,
		OP_IDLE,
		OP_SQ,
		OP_NEXT,
		OP_MUL,
		OP_CAP,
		OP_DIV,
		OP_ADD,
		OP_DONE
	} op_t;

	typedef enum logic [2:0] {
		CND_NONE,
		CND_NO_ACCEPT,
		CND_DIV_MORE,
		CND_STOP,
		CND_OUT_BUSY
	} cond_t;

	typedef struct packed {
		op_t             op;
		logic            a_hi;
		logic            b_hi;
		logic            mul_en;
		logic            acc_en;
		cond_t           cond;
		logic [PC_W-1:0] target;
		logic [PC_W-1:0] next;
	} uword_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

	localparam logic [PC_W-1:0] PC_IDLE = 4'd0;
	localparam logic [PC_W-1:0] PC_SQ   = 4'd1;
	localparam logic [PC_W-1:0] PC_NEXT = 4'd2;
	localparam logic [PC_W-1:0] PC_M0   = 4'd3;
	localparam logic [PC_W-1:0] PC_M1   = 4'd4;
	localparam logic [PC_W-1:0] PC_M2   = 4'd5;
	localparam logic [PC_W-1:0] PC_M3   = 4'd6;
	localparam logic [PC_W-1:0] PC_M4   = 4'd7;
	localparam logic [PC_W-1:0] PC_CAP  = 4'd8;
	localparam logic [PC_W-1:0] PC_DIV  = 4'd9;
	localparam logic [PC_W-1:0] PC_ADD  = 4'd10;
	localparam logic [PC_W-1:0] PC_DONE = 4'd11;

	function automatic uword_t ucode(input logic [PC_W-1:0] pc);
		uword_t w;
		w = '{OP_NOP, 1'b0, 1'b0, 1'b0, 1'b0, CND_NONE, PC_IDLE, PC_IDLE};
		case (pc)
			PC_IDLE: w = '{OP_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, CND_NO_ACCEPT, PC_IDLE, PC_SQ};
			PC_SQ:   w = '{OP_SQ,   1'b0, 1'b0, 1'b0, 1'b0, CND_NONE, PC_IDLE, PC_ADD};
			PC_NEXT: w = '{OP_NEXT, 1'b0, 1'b0, 1'b0, 1'b0, CND_NONE, PC_IDLE, PC_M0};
			PC_M0:   w = '{OP_MUL,  1'b0, 1'b0, 1'b1, 1'b0, CND_NONE, PC_IDLE, PC_M1};
			PC_M1:   w = '{OP_MUL,  1'b0, 1'b1, 1'b1, 1'b1, CND_NONE, PC_IDLE, PC_M2};
			PC_M2:   w = '{OP_MUL,  1'b1, 1'b0, 1'b1, 1'b1, CND_NONE, PC_IDLE, PC_M3};
			PC_M3:   w = '{OP_MUL,  1'b1, 1'b1, 1'b1, 1'b1, CND_NONE, PC_IDLE, PC_M4};
			PC_M4:   w = '{OP_MUL,  1'b0, 1'b0, 1'b0, 1'b1, CND_NONE, PC_IDLE, PC_CAP};
			PC_CAP:  w = '{OP_CAP,  1'b0, 1'b0, 1'b0, 1'b0, CND_NONE, PC_IDLE, PC_DIV};
			PC_DIV:  w = '{OP_DIV,  1'b0, 1'b0, 1'b0, 1'b0, CND_DIV_MORE, PC_DIV, PC_ADD};
			PC_ADD:  w = '{OP_ADD,  1'b0, 1'b0, 1'b0, 1'b0, CND_STOP, PC_DONE, PC_NEXT};
			PC_DONE: w = '{OP_DONE, 1'b0, 1'b0, 1'b0, 1'b0, CND_OUT_BUSY, PC_DONE, PC_IDLE};
			default: w = '{OP_NOP,  1'b0, 1'b0, 1'b0, 1'b0, CND_NONE, PC_IDLE, PC_IDLE};
		endcase
		return w;
	endfunction

endpackage

@@ sv/stc_divider.sv @@
// restoring divider, one quotient bit per step
module stc_divider import stc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  div_ctl_t         ctl,
	input  logic [MAG_W-1:0] dividend,
	input  logic [D_W-1:0]   divisor,
	output logic [MAG_W-1:0] quotient,
	output logic             more
);

	logic [MAG_W-1:0] quo_q;
	logic [D_W-1:0]   rem_q;
	logic [D_W-1:0]   dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic [D_W:0]     rem_sh;
	logic [D_W+1:0]   diff;
	logic             qbit;
	logic [D_W-1:0]   rem_nxt;

	always_comb begin
		rem_sh  = {rem_q, quo_q[MAG_W-1]};
		diff    = {1'b0, rem_sh} - {2'b00, dvs_q};
		qbit    = ~diff[D_W+1];
		rem_nxt = qbit ? diff[D_W-1:0] : rem_sh[D_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= CNT_W'(MAG_W - 1);
		end else if (ctl.step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (ctl.step) begin
			quo_q <= {quo_q[MAG_W-2:0], qbit};
			rem_q <= rem_nxt;
		end
	end

	assign quotient = quo_q;
	assign more     = (cnt_q != '0);

endmodule

@@ sv/sinc_taylor_series_top.sv @@
// sin(x)/x by its taylor series: microcoded sequencer, multiply and divide datapath
//
// Usage:
// - input channel: arg (s3.28 radians) with in_valid/in_stall; one word is taken
//   when the sequencer sits in its idle step, in_stall is high otherwise
// - output channel: series_sum (s15.32, saturating) and terms_used with
//   out_valid/out_stall, held in an output register; the next arg is taken
//   while a finished result still waits there
// - config: cfg_wr_en/cfg_index/cfg_data; index 0 is the tolerance, index 1
//   the largest term count; write only while the block is idle
// Sequence:
// - each further term passes the multiply steps through the 32x32 multiplier
//   (four partial products), one cap step and the one-bit-per-cycle divider
// - the default term limit is 16 terms
// - after the sum is done the sequencer waits in its final step while the
//   output register is still full and stalled, and takes no new word
// Reset: sequencer goes to idle, output register empties, tolerance and term
// limit take their defaults, the kept x^2 clears.
module sinc_taylor_series_top import stc_pkg::*; #(
	parameter int TERM_LIMIT = TERM_LIMIT_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic [0:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [ARG_W-1:0] arg,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [SUM_W-1:0] series_sum,
	output logic [USED_W-1:0]       terms_used
);

	localparam int SQ_SH = 2 * ARG_FRAC - FRAC_BITS;
	localparam int X_W   = MAG_W + 2;
	localparam logic [USED_W-1:0] LIMIT_MAX = USED_W'(TERM_LIMIT);
	localparam logic [MAG_W-1:0]  MAG_ONE   = MAG_W'(1) << FRAC_BITS;
	localparam logic [MAG_W-1:0]  MAG_CAP   = MAG_W'(1) << (MAG_W - 1);
	localparam logic signed [X_W-1:0] SUM_MAX_X = X_W'((64'(1) << (SUM_W - 1)) - 1);
	localparam logic signed [X_W-1:0] SUM_MIN_X = -SUM_MAX_X - X_W'(1);

	logic [PC_W-1:0]          pc_q;
	uword_t                   uw;
	logic [TOL_W-1:0]         tolerance_q;
	logic [USED_W-1:0]        max_terms_q;
	logic [USED_W-1:0]        limit_q;
	logic [USED_W-1:0]        used_q;
	logic [SQ_W-1:0]          arg_squared_q;
	logic                     neg_q;
	logic                     first_q;
	logic                     out_valid_q;
	logic [ARG_W-1:0]         amag_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [MAG_W-1:0]         mag_q;
	logic [D_W-1:0]           d_q;
	logic [2*ARG_W-1:0]       pp_s1;
	logic [1:0]               pp_sh_s1;
	logic [ACC_W-1:0]         acc_q;
	logic signed [SUM_W-1:0]  series_sum_q;
	logic [USED_W-1:0]        terms_used_q;

	logic                     accept;
	logic                     out_busy;
	logic                     taken;
	logic [ARG_W-1:0]         amag;
	logic [USED_W-1:0]        limit_new;
	logic [2*ARG_W-1:0]       sq_prod;
	logic [ARG_W-1:0]         mul_a;
	logic [ARG_W-1:0]         mul_b;
	logic [ACC_W-1:0]         pp_ext;
	logic [ACC_W-1:0]         acc_sh;
	logic [MAG_W-1:0]         mag_capped;
	logic [7:0]               two_k;
	logic [MAG_W-1:0]         mag_add;
	logic signed [X_W-1:0]    sum_raw;
	logic signed [SUM_W-1:0]  sum_new;
	logic [USED_W-1:0]        used_inc;
	logic                     stop;
	logic                     div_more;
	logic [MAG_W-1:0]         div_quo;
	div_ctl_t                 div_ctl;

	assign uw       = ucode(pc_q);
	assign in_stall = (uw.op != OP_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_busy = out_valid_q && out_stall;

	always_comb begin
		amag = arg[ARG_W-1] ? (~arg + 1'b1) : arg;
		if (max_terms_q == '0) begin
			limit_new = USED_W'(1);
		end else if (max_terms_q > LIMIT_MAX) begin
			limit_new = LIMIT_MAX;
		end else begin
			limit_new = max_terms_q;
		end
	end

	always_comb begin
		sq_prod = amag_q * amag_q;
		mul_a   = uw.a_hi ? {1'b0, mag_q[MAG_W-1:ARG_W]} : mag_q[ARG_W-1:0];
		mul_b   = uw.b_hi ? arg_squared_q[SQ_W-1:ARG_W] : arg_squared_q[ARG_W-1:0];
		case (pp_sh_s1)
			2'd1:    pp_ext = {32'b0, pp_s1, 32'b0};
			2'd2:    pp_ext = {pp_s1, 64'b0};
			default: pp_ext = {64'b0, pp_s1};
		endcase
		acc_sh     = acc_q >> FRAC_BITS;
		mag_capped = (acc_sh > ACC_W'(MAG_CAP)) ? MAG_CAP : acc_sh[MAG_W-1:0];
		two_k      = {used_q, 1'b0};
	end

	always_comb begin
		mag_add  = first_q ? MAG_ONE : div_quo;
		sum_raw  = neg_q ? (X_W'(sum_q) - $signed({2'b00, mag_add}))
		                 : (X_W'(sum_q) + $signed({2'b00, mag_add}));
		if (sum_raw > SUM_MAX_X) begin
			sum_new = SUM_MAX_X[SUM_W-1:0];
		end else if (sum_raw < SUM_MIN_X) begin
			sum_new = SUM_MIN_X[SUM_W-1:0];
		end else begin
			sum_new = sum_raw[SUM_W-1:0];
		end
		used_inc = used_q + 1'b1;
		stop     = (mag_add < MAG_W'(tolerance_q)) || (used_inc == limit_q);
	end

	always_comb begin
		case (uw.cond)
			CND_NO_ACCEPT: taken = !in_valid;
			CND_DIV_MORE:  taken = div_more;
			CND_STOP:      taken = stop;
			CND_OUT_BUSY:  taken = out_busy;
			default:       taken = 1'b0;
		endcase
		div_ctl.load = (uw.op == OP_CAP);
		div_ctl.step = (uw.op == OP_DIV);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q          <= PC_IDLE;
			tolerance_q   <= TOL_RST;
			max_terms_q   <= MAX_TERMS_RST;
			limit_q       <= USED_W'(1);
			used_q        <= '0;
			arg_squared_q <= '0;
			neg_q         <= 1'b0;
			first_q       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			pc_q <= taken ? uw.target : uw.next;
			if (cfg_wr_en) begin
				case (reg_idx_t'(cfg_index))
					REG_TOLERANCE: tolerance_q <= cfg_data[TOL_W-1:0];
					REG_MAX_TERMS: max_terms_q <= cfg_data[USED_W-1:0];
					default: ;
				endcase
			end
			if (out_valid_q && !out_stall && uw.op != OP_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (uw.op)
				OP_IDLE: begin
					if (accept) begin
						limit_q <= limit_new;
						used_q  <= '0;
						neg_q   <= 1'b0;
						first_q <= 1'b1;
					end
				end
				OP_SQ: begin
					arg_squared_q <= SQ_W'(sq_prod >> SQ_SH);
				end
				OP_CAP: begin
					neg_q <= !neg_q;
				end
				OP_ADD: begin
					used_q  <= used_inc;
					first_q <= 1'b0;
				end
				OP_DONE: begin
					if (!out_busy) begin
						out_valid_q <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			amag_q <= amag;
			sum_q  <= '0;
		end
		if (uw.op == OP_NEXT) begin
			d_q   <= D_W'(two_k * (two_k | 8'd1));
			acc_q <= '0;
		end
		if (uw.mul_en) begin
			pp_s1    <= mul_a * mul_b;
			pp_sh_s1 <= 2'(uw.a_hi) + 2'(uw.b_hi);
		end
		if (uw.acc_en) begin
			acc_q <= acc_q + pp_ext;
		end
		if (uw.op == OP_ADD) begin
			sum_q <= sum_new;
			mag_q <= mag_add;
		end
		if (uw.op == OP_DONE && !out_busy) begin
			series_sum_q <= sum_q;
			terms_used_q <= used_q;
		end
	end

	stc_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (mag_capped),
		.divisor  (d_q),
		.quotient (div_quo),
		.more     (div_more)
	);

	assign out_valid  = out_valid_q;
	assign series_sum = series_sum_q;
	assign terms_used = terms_used_q;

	a_accept_to_sq: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> pc_q == PC_SQ)
		else $error("accepted word did not start the square step");

	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q != PC_IDLE) |-> used_q <= limit_q)
		else $error("term count ran past the limit");

	a_limit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q != PC_IDLE) |-> (limit_q != '0 && limit_q <= LIMIT_MAX))
		else $error("term limit out of range");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (terms_used_q != '0 && terms_used_q <= limit_q))
		else $error("result carries a bad term count");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(pc_q) == PC_DONE)
		else $error("output loaded outside the final step");

endmodule

@@ dv/tb_sinc_taylor_series_top.sv @@
// testbench for the sinc taylor series evaluator: directed and random args against a predictor
module tb_sinc_taylor_series_top;
	timeunit 1ns;
	timeprecision 1ps;
	import stc_pkg::*;

	localparam int CYCLE_LIMIT = 20_000_000;
	localparam logic [63:0] MAG_CAP = 64'd1 << 62;
	localparam longint SUM_HI = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint SUM_LO = -SUM_HI - 64'sd1;

	typedef struct packed {
		logic signed [SUM_W-1:0] sum;
		logic [USED_W-1:0]       used;
	} sinc_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic [0:0]              cfg_index = REG_TOLERANCE;
	logic [CFG_W-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [ARG_W-1:0] arg = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [SUM_W-1:0] series_sum;
	logic [USED_W-1:0]       terms_used;

	logic [TOL_W-1:0]  tol_reg = TOL_RST;
	logic [USED_W-1:0] term_cap_reg = MAX_TERMS_RST;
	sinc_result_t      sum_q[$];

	int  errors = 0;
	int  sent = 0;
	int  checked = 0;
	int  writes = 0;
	int  cycles = 0;
	int  hold_cycles = 0;
	int  burst_left = 0;
	bit  idle_on = 1'b1;
	bit  stall_on = 1'b1;

	sinc_taylor_series_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.arg        (arg),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.series_sum (series_sum),
		.terms_used (terms_used)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic sinc_result_t sinc_series(input logic signed [ARG_W-1:0] x,
			input logic [TOL_W-1:0] tol, input logic [USED_W-1:0] cap);
		sinc_result_t res;
		logic [31:0]  amag;
		logic [63:0]  sq;
		logic [63:0]  mag;
		logic [63:0]  q;
		logic [127:0] prod;
		longint       acc;
		logic         neg;
		int           lim;
		int           n;
		amag = x[ARG_W-1] ? (~x + 32'd1) : x;
		sq = ({32'd0, amag} * {32'd0, amag}) >> (2 * ARG_FRAC - FRAC_BITS_DEF);
		lim = cap;
		if (lim < 1)
			lim = 1;
		if (lim > TERM_LIMIT_DEF)
			lim = TERM_LIMIT_DEF;
		mag = 64'd1 << FRAC_BITS_DEF;
		neg = 1'b0;
		acc = 0;
		n = 0;
		for (int k = 0; k < lim; k++) begin
			if (k > 0) begin
				prod = {64'd0, mag} * {64'd0, sq};
				if (prod[127:96] != 32'd0) begin
					q = MAG_CAP;
				end else begin
					q = prod[95:32];
					if (q > MAG_CAP)
						q = MAG_CAP;
				end
				mag = q / 64'(2 * k * (2 * k + 1));
				neg = !neg;
			end
			acc = neg ? acc - longint'(mag) : acc + longint'(mag);
			if (acc > SUM_HI)
				acc = SUM_HI;
			if (acc < SUM_LO)
				acc = SUM_LO;
			n++;
			if (mag < {32'd0, tol})
				break;
		end
		res.sum = acc[SUM_W-1:0];
		res.used = n[USED_W-1:0];
		return res;
	endfunction

	always @(negedge clk) begin
		if (hold_cycles > 0) begin
			out_stall = 1'b1;
			hold_cycles--;
		end else if (burst_left > 0) begin
			out_stall = 1'b1;
			burst_left--;
		end else if (stall_on && $urandom_range(0, 3) == 0) begin
			out_stall = 1'b1;
			burst_left = $urandom_range(0, 4);
		end else begin
			out_stall = 1'b0;
		end
	end

	always @(posedge clk) begin : check_result
		sinc_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (sum_q.size() == 0) begin
				$error("result word with no pending arg: series_sum %0d terms_used %0d",
					series_sum, terms_used);
				errors++;
			end else begin
				want = sum_q.pop_front();
				checked++;
				if (series_sum !== want.sum) begin
					$error("series_sum: expected %0d, actual %0d", want.sum, series_sum);
					errors++;
				end
				if (terms_used !== want.used) begin
					$error("terms_used: expected %0d, actual %0d", want.used, terms_used);
					errors++;
				end
			end
		end
	end

	task automatic send_arg(input logic signed [ARG_W-1:0] x);
		int gap;
		@(negedge clk);
		gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		arg = x;
		do
			@(posedge clk);
		while (in_stall);
		sum_q.push_back(sinc_series(x, tol_reg, term_cap_reg));
		sent++;
	endtask

	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sum_q.size() != 0)
			@(posedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_wr_en = 1'b0;
		if (idx == REG_TOLERANCE)
			tol_reg = val[TOL_W-1:0];
		else
			term_cap_reg = val[USED_W-1:0];
		writes++;
	endtask

	task automatic test_defaults();
		send_arg(32'sd0);
		send_arg(32'sd1 <<< ARG_FRAC);
		send_arg(-(32'sd1 <<< ARG_FRAC));
		send_arg(32'sd843314857);
		send_arg(32'sd1);
		send_arg(-32'sd1);
		send_arg(32'h7FFF_FFFF);
		send_arg(32'h8000_0000);
	endtask

	task automatic test_term_limits();
		settle();
		write_reg(REG_TOLERANCE, 32'd0);
		write_reg(REG_MAX_TERMS, 32'd0);
		send_arg(32'sd1 <<< ARG_FRAC);
		send_arg(32'h7FFF_FFFF);
		settle();
		write_reg(REG_MAX_TERMS, 32'd64);
		send_arg(32'h8000_0000);
		send_arg(32'sd1 <<< 20);
		settle();
		write_reg(REG_TOLERANCE, 32'd1);
		write_reg(REG_MAX_TERMS, 32'hFFFF_FFFF);
		send_arg(32'h4000_0000);
	endtask

	task automatic test_tolerance_edges();
		settle();
		write_reg(REG_TOLERANCE, 32'hFFFF_FFFF);
		write_reg(REG_MAX_TERMS, 32'd16);
		send_arg(32'h7FFF_FFFF);
		send_arg(32'sd1 <<< ARG_FRAC);
		send_arg(32'sd0);
	endtask

	task automatic test_backpressure();
		settle();
		write_reg(REG_TOLERANCE, 32'd0);
		write_reg(REG_MAX_TERMS, 32'd2);
		hold_cycles = 600;
		for (int i = 0; i < 6; i++)
			send_arg($urandom);
	endtask

	task automatic test_random();
		logic [31:0]       r;
		logic [31:0]       x;
		logic [TOL_W-1:0]  tol;
		logic [USED_W-1:0] cap;
		int                n;
		for (int p = 0; p < 10; p++) begin
			settle();
			idle_on = (p < 8);
			stall_on = (p < 8);
			case ($urandom_range(0, 3))
				0: tol = 32'd0;
				1: tol = $urandom_range(1, 65536);
				2: tol = $urandom;
				default: tol = 32'hFFFF_FFFF;
			endcase
			cap = (p == 3) ? 7'($urandom_range(64, 127)) : 7'($urandom_range(0, 20));
			r = $urandom;
			write_reg(REG_TOLERANCE, tol);
			write_reg(REG_MAX_TERMS, {r[31:7], cap});
			n = (p == 3) ? 12 : 48;
			repeat (n) begin
				r = $urandom;
				case ($urandom_range(0, 3))
					0: x = r;
					1: x = r[31] ? -{4'd0, r[27:0]} : {4'd0, r[27:0]};
					2: x = r[31] ? -{8'd0, r[23:0]} : {8'd0, r[23:0]};
					default: begin
						case ($urandom_range(0, 4))
							0: x = 32'd0;
							1: x = 32'h7FFF_FFFF;
							2: x = 32'h8000_0000;
							3: x = 32'd1;
							default: x = 32'hFFFF_FFFF;
						endcase
					end
				endcase
				send_arg(x);
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_defaults();
		test_term_limits();
		test_tolerance_edges();
		test_backpressure();
		test_random();
		settle();
		repeat (20) @(posedge clk);
		if (sum_q.size() != 0) begin
			$error("%0d sums never came out", sum_q.size());
			errors++;
		end
		$display("ran %0d args over %0d register writes, %0d result words compared",
			sent, writes, checked);
		$display("term caps 0..127, tolerance 0 to all ones, long output hold-off included");
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
